// ----- src/brf_pkg.sv -----
`timescale 1ns / 1ps

package brf_pkg;

    // Default geometry of the ring and the longest burst one drain may emit.
    localparam int DEPTH_DEF     = 512;
    localparam int MAX_BURST_DEF = 64;

    // Width of the fill count reported with every result.
    localparam int FILL_W = 9;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_DRAIN = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

    // One result as the sequencer describes it. The byte itself comes from
    // the RAM read port when from_ram is set.
    typedef struct packed {
        logic              emit;
        logic              from_ram;
        logic              valid;
        logic              empty;
        logic              full;
        logic              ovf;
        logic [FILL_W-1:0] fill;
        logic              last;
    } t_res;

endpackage

// ----- src/brf_ram.sv -----
`timescale 1ns / 1ps

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/brf_seq.sv -----
`timescale 1ns / 1ps

module brf_seq #(
    parameter int DEPTH     = brf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [1:0]                             i_command,
    input  logic [7:0]                             i_data_in,
    input  logic [7:0]                             i_tx_space,
    output logic                                   o_busy,
    output logic                                   o_we,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_waddr,
    output logic [7:0]                             o_wdata,
    output logic                                   o_re,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_raddr,
    output brf_pkg::t_res                          o_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam int CW = (PW > 8) ? PW : 8;
    localparam int OW = (PW > brf_pkg::FILL_W) ? PW : brf_pkg::FILL_W;

    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [7:0]    BURST_CAP = 8'(MAX_BURST);

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [brf_pkg::FILL_W-1:0] fill_out(input logic [PW-1:0] f);
        logic [OW-1:0] w;
        w = OW'(f);
        return w[brf_pkg::FILL_W-1:0];
    endfunction

    brf_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [PW-1:0]   r_fill, n_fill;
    logic            r_ovf, n_ovf;
    logic [BW-1:0]   r_left, n_left;

    brf_pkg::t_cmd   cmd;
    logic            accept;
    logic            now_empty;
    logic            now_full;
    logic [7:0]      space_sat;
    logic [CW-1:0]   fill_c;
    logic [CW-1:0]   space_c;
    logic [CW-1:0]   burst_c;
    logic [BW-1:0]   burst;
    logic            go_stream;
    logic [PW-1:0]   stat_fill;

    assign cmd       = brf_pkg::t_cmd'(i_command);
    assign accept    = i_start && (r_state == brf_pkg::ST_IDLE);
    assign now_empty = (r_fill == '0);
    assign now_full  = (r_fill == LAST_PTR);
    assign space_sat = (i_tx_space > BURST_CAP) ? BURST_CAP : i_tx_space;
    assign fill_c    = CW'(r_fill);
    assign space_c   = CW'(space_sat);
    assign burst_c   = (fill_c < space_c) ? fill_c : space_c;
    assign burst     = BW'(burst_c);
    assign go_stream = accept &&
                       (((cmd == brf_pkg::CMD_POP) && !now_empty) ||
                        ((cmd == brf_pkg::CMD_DRAIN) && (burst != '0)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brf_pkg::ST_IDLE: begin
                if (go_stream) begin
                    n_state = brf_pkg::ST_STREAM;
                end
            end
            brf_pkg::ST_STREAM: begin
                if (r_left == '0) begin
                    n_state = brf_pkg::ST_IDLE;
                end
            end
            default: n_state = brf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_left    = r_left;
        o_we      = 1'b0;
        o_re      = 1'b0;
        o_res     = '0;
        stat_fill = r_fill;
        unique case (r_state)
            brf_pkg::ST_IDLE: begin
                if (accept) begin
                    o_res.last = 1'b1;
                    unique case (cmd)
                        brf_pkg::CMD_PUSH: begin
                            if (now_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                o_we   = 1'b1;
                                n_wp   = next_ptr(r_wp);
                                n_fill = r_fill + 1'b1;
                                n_ovf  = 1'b0;
                            end
                            o_res.emit = 1'b1;
                            stat_fill  = n_fill;
                        end
                        brf_pkg::CMD_POP: begin
                            if (now_empty) begin
                                o_res.emit = 1'b1;
                            end else begin
                                o_re   = 1'b1;
                                n_rp   = next_ptr(r_rp);
                                n_fill = r_fill - 1'b1;
                                n_left = '0;
                            end
                        end
                        brf_pkg::CMD_DRAIN: begin
                            if (burst == '0) begin
                                o_res.emit = 1'b1;
                            end else begin
                                o_re   = 1'b1;
                                n_rp   = next_ptr(r_rp);
                                n_fill = r_fill - 1'b1;
                                n_left = burst - 1'b1;
                            end
                        end
                        brf_pkg::CMD_NONE: begin
                            o_res.emit = 1'b1;
                        end
                        default: o_res.emit = 1'b1;
                    endcase
                end
            end
            brf_pkg::ST_STREAM: begin
                // The byte read last cycle is on the RAM port now; r_fill already
                // counts it as gone.
                o_res.emit     = 1'b1;
                o_res.from_ram = 1'b1;
                o_res.valid    = 1'b1;
                o_res.last     = (r_left == '0);
                if (r_left != '0) begin
                    o_re   = 1'b1;
                    n_rp   = next_ptr(r_rp);
                    n_fill = r_fill - 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            default: o_res = '0;
        endcase
        o_res.ovf   = n_ovf;
        o_res.fill  = fill_out(stat_fill);
        o_res.empty = (stat_fill == '0);
        o_res.full  = (stat_fill == LAST_PTR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brf_pkg::ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_left  <= n_left;
        end
    end

    assign o_busy  = (r_state == brf_pkg::ST_STREAM);
    assign o_waddr = r_wp;
    assign o_wdata = i_data_in;
    assign o_raddr = r_rp;

endmodule

// ----- src/byte_ring_fifo_with_burst_drain.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Ports
// -------   --------------------   ------------------------------------------------
// command   i_start & !o_busy      i_command, i_data_in, i_tx_space
// result    o_strobe (one cycle)   o_data_out, o_data_valid, o_is_empty, o_is_full,
//                                  o_overflow, o_fill_count, o_last
//
// A push, a pop or drain that finds nothing to send, and the unused command all
// answer with one word in the cycle after they are taken, and o_busy stays low, so a
// new command may follow in every cycle. A pop that finds a byte raises o_busy for
// one cycle and answers through the RAM read register and then the result register.
// A drain of n bytes holds o_busy high while it streams and emits one word per
// cycle; each byte passes through the RAM read register and the result register.
// Reset is synchronous and active low; it clears the pointers, the fill count and
// the overflow flag, but not the RAM. The receiver cannot stall the result words.
module byte_ring_fifo_with_burst_drain #(
    parameter int DEPTH     = brf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [1:0]                 i_command,
    input  logic [7:0]                 i_data_in,
    input  logic [7:0]                 i_tx_space,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [7:0]                 o_data_out,
    output logic                       o_data_valid,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic                       o_overflow,
    output logic [brf_pkg::FILL_W-1:0] o_fill_count,
    output logic                       o_last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    brf_pkg::t_res res;

    logic                       r_strobe;
    logic [7:0]                 r_data_out;
    logic                       r_data_valid;
    logic                       r_is_empty;
    logic                       r_is_full;
    logic                       r_overflow;
    logic [brf_pkg::FILL_W-1:0] r_fill_count;
    logic                       r_last;

    // Reads only ever touch entries that a push wrote in an earlier cycle, and no
    // push is taken while a pop or drain is reading, so the RAM needs no forwarding.
    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The sequencer owns the pointers, the fill count and the overflow flag, and
    // describes one result word per cycle.
    brf_seq #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_command  (i_command),
        .i_data_in  (i_data_in),
        .i_tx_space (i_tx_space),
        .o_busy     (o_busy),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .o_res      (res)
    );

    // The result register: it holds each word for exactly one cycle and lets the
    // sequencer take the next command while the word is shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_out   <= res.from_ram ? ram_rdata : 8'h00;
        r_data_valid <= res.valid;
        r_is_empty   <= res.empty;
        r_is_full    <= res.full;
        r_overflow   <= res.ovf;
        r_fill_count <= res.fill;
        r_last       <= res.last;
    end

    assign o_strobe     = r_strobe;
    assign o_data_out   = r_data_out;
    assign o_data_valid = r_data_valid;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;
    assign o_overflow   = r_overflow;
    assign o_fill_count = r_fill_count;
    assign o_last       = r_last;

    // A burst that has not ended goes on in the very next cycle.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("drain burst broke off before its last word");

    // Every accepted command either answers at once or holds the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_strobe || o_busy))
        else $error("accepted command produced neither a word nor busy");

    // A word that carries no real byte shows a zero byte.
    a_idle_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_data_valid) |-> (o_data_out == 8'h00))
        else $error("status-only word carries a nonzero byte");

    // Empty and full never hold together, and empty means a zero count.
    a_status_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!(o_is_empty && o_is_full) && (!o_is_empty || o_fill_count == '0)))
        else $error("inconsistent status on a result word");

endmodule

// ----- bench/byte_ring_fifo_with_burst_drain_tb.sv -----
`timescale 1ns / 1ps

// The bench feeds the ring FIFO with push, pop, drain and unused commands.
// It keeps its own model of the ring, and it checks every result word that
// the block strobes out against the words that this model predicts.
module byte_ring_fifo_with_burst_drain_tb;

    localparam int RING  = brf_pkg::DEPTH_DEF;
    localparam int BURST = brf_pkg::MAX_BURST_DEF;
    localparam int PTR_W = $clog2(RING);

    // One command as the stimulus describes it. The gap is the number of idle
    // cycles the driver inserts before offering this command. When quiet is set,
    // the driver also holds the command back until every predicted word has come.
    typedef struct {
        brf_pkg::t_cmd cmd;
        logic [7:0]    data;
        logic [7:0]    space;
        int            gap;
        bit            quiet;
    } t_order;

    // One result word, laid out in the same order as the result ports.
    typedef struct packed {
        logic [7:0]                 data;
        logic                       valid;
        logic                       empty;
        logic                       full;
        logic                       ovf;
        logic [brf_pkg::FILL_W-1:0] fill;
        logic                       last;
    } t_word;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_start    = 1'b0;
    logic [1:0]                 i_command  = brf_pkg::CMD_NONE;
    logic [7:0]                 i_data_in  = 8'h00;
    logic [7:0]                 i_tx_space = 8'h00;
    logic                       o_busy;
    logic                       o_strobe;
    logic [7:0]                 o_data_out;
    logic                       o_data_valid;
    logic                       o_is_empty;
    logic                       o_is_full;
    logic                       o_overflow;
    logic [brf_pkg::FILL_W-1:0] o_fill_count;
    logic                       o_last;

    t_order command_backlog[$];
    t_word  expected_words[$];
    t_order in_flight;
    int     total_orders = 0;
    int     orders_taken = 0;
    int     mismatches   = 0;

    // This is the ring as the bench sees it. Entries that were never written
    // are never read, because every pop and every drain is bounded by the fill.
    logic [7:0]       ring_bytes [RING];
    logic [PTR_W-1:0] wr_ptr   = '0;
    logic [PTR_W-1:0] rd_ptr   = '0;
    logic             ovf_flag = 1'b0;

    byte_ring_fifo_with_burst_drain i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_command   (i_command),
        .i_data_in   (i_data_in),
        .i_tx_space  (i_tx_space),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_data_out  (o_data_out),
        .o_data_valid(o_data_valid),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_overflow  (o_overflow),
        .o_fill_count(o_fill_count),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // The status fields describe the ring after this word's byte has left it.
    function automatic t_word ring_status_word(logic [7:0] b, logic v, logic l);
        t_word w;
        w.data  = b;
        w.valid = v;
        w.empty = (wr_ptr == rd_ptr);
        w.full  = (PTR_W'(wr_ptr + 1'b1) == rd_ptr);
        w.ovf   = ovf_flag;
        w.fill  = brf_pkg::FILL_W'(PTR_W'(wr_ptr - rd_ptr));
        w.last  = l;
        return w;
    endfunction

    // This task advances the ring by one accepted command, and it queues the
    // words that the command must produce.
    task automatic predict_ring_words(t_order o);
        int         avail;
        int         cap;
        int         k;
        logic [7:0] b;
        case (o.cmd)
            brf_pkg::CMD_PUSH: begin
                if (PTR_W'(wr_ptr + 1'b1) == rd_ptr) begin
                    ovf_flag = 1'b1;
                end else begin
                    ring_bytes[wr_ptr] = o.data;
                    wr_ptr   = wr_ptr + 1'b1;
                    ovf_flag = 1'b0;
                end
                expected_words.push_back(ring_status_word(8'h00, 1'b0, 1'b1));
            end
            brf_pkg::CMD_POP: begin
                if (wr_ptr == rd_ptr) begin
                    expected_words.push_back(ring_status_word(8'h00, 1'b0, 1'b1));
                end else begin
                    b      = ring_bytes[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    expected_words.push_back(ring_status_word(b, 1'b1, 1'b1));
                end
            end
            brf_pkg::CMD_DRAIN: begin
                // A drain sends the smaller of the fill and the sink space, and the
                // sink space is first clipped to the longest burst.
                avail = int'(PTR_W'(wr_ptr - rd_ptr));
                cap   = (int'(o.space) > BURST) ? BURST : int'(o.space);
                if (avail > cap) avail = cap;
                if (avail == 0) begin
                    expected_words.push_back(ring_status_word(8'h00, 1'b0, 1'b1));
                end else begin
                    for (k = 0; k < avail; k++) begin
                        b      = ring_bytes[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        expected_words.push_back(ring_status_word(b, 1'b1, k == avail - 1));
                    end
                end
            end
            default: begin
                expected_words.push_back(ring_status_word(8'h00, 1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(string why, t_word want, t_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at %0t ns", why, $realtime);
            $display("  expected data=%h valid=%b empty=%b full=%b ovf=%b fill=%0d last=%b",
                     want.data, want.valid, want.empty, want.full, want.ovf, want.fill,
                     want.last);
            $display("  actual   data=%h valid=%b empty=%b full=%b ovf=%b fill=%0d last=%b",
                     got.data, got.valid, got.empty, got.full, got.ovf, got.fill, got.last);
        end
    endtask

    task automatic add_order(brf_pkg::t_cmd c, logic [7:0] d, logic [7:0] s, int gap,
                             bit quiet);
        t_order o;
        o.cmd   = c;
        o.data  = d;
        o.space = s;
        o.gap   = gap;
        o.quiet = quiet;
        command_backlog.push_back(o);
    endtask

    // Driver. A command is taken at an edge where i_start is high and o_busy is
    // low, and the prediction for it is made at that edge. i_start gets exactly
    // one nonblocking assignment per edge, so back-to-back commands keep it high.
    always @(posedge i_clk) begin : drive_proc
        logic start_next;
        start_next = i_start;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predict_ring_words(in_flight);
                orders_taken++;
                start_next = 1'b0;
            end
            if (!start_next && command_backlog.size() > 0) begin
                if (command_backlog[0].gap > 0) begin
                    command_backlog[0].gap--;
                end else if (!(command_backlog[0].quiet && expected_words.size() != 0)) begin
                    in_flight  = command_backlog.pop_front();
                    i_command  <= in_flight.cmd;
                    i_data_in  <= in_flight.data;
                    i_tx_space <= in_flight.space;
                    start_next = 1'b1;
                end
            end
        end
        i_start <= start_next;
    end

    // Monitor. Each strobed word is taken at the edge that closes its cycle. At
    // that edge it is matched against the oldest word that is still expected.
    always @(posedge i_clk) begin : check_proc
        t_word got;
        t_word want;
        if (i_rst_n && o_strobe) begin
            got = {o_data_out, o_data_valid, o_is_empty, o_is_full, o_overflow,
                   o_fill_count, o_last};
            if (expected_words.size() == 0) begin
                report_mismatch("Unexpected result word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.data !== want.data || got.valid !== want.valid ||
                    got.empty !== want.empty || got.full !== want.full ||
                    got.ovf !== want.ovf || got.fill !== want.fill ||
                    got.last !== want.last) begin
                    report_mismatch("Result word mismatch", want, got);
                end
            end
        end
    end

    initial begin : stimulus_proc
        int            i;
        int            pick;
        int            gap;
        bit            calm;
        bit            quiet;
        brf_pkg::t_cmd c;
        logic [7:0]    s;

        // The directed part starts on an empty ring: a pop, drains with no space
        // and with full space, and the unused command. It then pushes both
        // extreme bytes, and it drains with no space, with one slot, with exactly
        // one burst, with one over a burst, and with the widest sink value.
        add_order(brf_pkg::CMD_POP,   8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'h00, 1, 1'b0);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'hFF, 0, 1'b0);
        add_order(brf_pkg::CMD_NONE,  8'hFF, 8'hFF, 2, 1'b0);
        add_order(brf_pkg::CMD_PUSH,  8'h00, 8'hFF, 0, 1'b0);
        add_order(brf_pkg::CMD_PUSH,  8'hFF, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_PUSH,  8'hA5, 8'h5A, 3, 1'b0);
        add_order(brf_pkg::CMD_PUSH,  8'h5A, 8'hA5, 0, 1'b0);
        add_order(brf_pkg::CMD_POP,   8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_POP,   8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'h01, 0, 1'b0);
        add_order(brf_pkg::CMD_NONE,  8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'hFF, 4, 1'b0);
        for (i = 0; i < 70; i++) begin
            add_order(brf_pkg::CMD_PUSH, 8'(i * 37 + 11), 8'(i), 0, 1'b0);
        end
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'd64, 0, 1'b0);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'd65, 0, 1'b0);
        add_order(brf_pkg::CMD_POP,   8'h00, 8'h00, 0, 1'b0);

        // The sender pauses until the ring has answered everything. A drain with
        // no space, a pop and a few pushes follow, and wide drains empty the ring.
        add_order(brf_pkg::CMD_PUSH,  8'h3C, 8'h00, 0, 1'b1);
        add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_POP,   8'h00, 8'h00, 0, 1'b0);
        add_order(brf_pkg::CMD_PUSH,  8'hC3, 8'h00, 1, 1'b0);
        add_order(brf_pkg::CMD_PUSH,  8'h96, 8'h00, 0, 1'b0);
        for (i = 0; i < 2; i++) begin
            add_order(brf_pkg::CMD_DRAIN, 8'h00, 8'hFF, $urandom_range(0, 4), 1'b0);
        end

        // The random part mixes commands with random content. It runs in stretches
        // of twenty commands that either never idle or idle at random, and a few
        // commands wait for the ring to go quiet. The sink space is mostly small,
        // so that short drains are common.
        calm = 1'b0;
        for (i = 0; i < 37; i++) begin
            if (i % 20 == 0) calm = $urandom_range(0, 1);
            gap   = calm ? 0 : $urandom_range(0, 4);
            quiet = ($urandom_range(0, 29) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 45)      c = brf_pkg::CMD_PUSH;
            else if (pick < 65) c = brf_pkg::CMD_POP;
            else if (pick < 90) c = brf_pkg::CMD_DRAIN;
            else                c = brf_pkg::CMD_NONE;
            s = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 12));
            add_order(c, 8'($urandom_range(0, 255)), s, gap, quiet);
        end
        total_orders = command_backlog.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (orders_taken < total_orders) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (BURST + 8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // This is a watchdog. The slowest correct run stays well under a millisecond.
    initial begin : watchdog_proc
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
